@@ rtl/gbs_pkg.sv @@
// Shared types, widths and helpers for the greedy box suppression block.
// Used by the channel interfaces, the kept-box cell and the top level.
package gbs_pkg;

	localparam int COORD_W     = 16;
	localparam int EXT_W       = COORD_W + 1;
	localparam int AREA_W      = 2 * EXT_W;
	localparam int SUM_W       = AREA_W + 1;
	localparam int THR_W       = 9;
	localparam int IOU_SHIFT   = 8;
	localparam int PROD_W      = THR_W + SUM_W;
	localparam int PIXEL_ONE   = 16;
	localparam int MAX_KEPT_DEF = 64;

	localparam logic [THR_W-1:0] THR_RESET = 9'd102;

	typedef struct packed {
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] right;
		logic [COORD_W-1:0] bottom;
	} box_t;

	// A box travelling down the cell chain.
	typedef struct packed {
		logic              valid;
		box_t              box;
		logic [AREA_W-1:0] area;
	} box_bus_t;

	// Write of a surviving box into the next free cell.
	typedef struct packed {
		logic              en;
		box_t              box;
		logic [AREA_W-1:0] area;
	} store_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXT,
		ST_AREA,
		ST_LAUNCH,
		ST_WALK,
		ST_FINISH
	} state_t;

	// Extent from lo to hi with the one-pixel margin, clamped at zero.
	function automatic logic [EXT_W-1:0] extent(input logic [COORD_W-1:0] lo,
		input logic [COORD_W-1:0] hi);
		logic [EXT_W-1:0] upper;
		upper = EXT_W'(hi) + EXT_W'(PIXEL_ONE);
		if (upper > EXT_W'(lo)) begin
			return upper - EXT_W'(lo);
		end
		return '0;
	endfunction

endpackage

@@ rtl/gbs_box_if.sv @@
// Input channel carrying one detection box per transfer.
// Field widths come from gbs_pkg.
interface gbs_box_if;
	logic                        valid;
	logic                        ready;
	logic                        first_box;
	logic [gbs_pkg::COORD_W-1:0] left;
	logic [gbs_pkg::COORD_W-1:0] top;
	logic [gbs_pkg::COORD_W-1:0] right;
	logic [gbs_pkg::COORD_W-1:0] bottom;
	logic [gbs_pkg::COORD_W-1:0] confidence;
	logic [gbs_pkg::COORD_W-1:0] tag;

	modport source (output valid, first_box, left, top, right, bottom, confidence, tag,
		input ready);
	modport sink (input valid, first_box, left, top, right, bottom, confidence, tag,
		output ready);
endinterface

@@ rtl/gbs_kept_if.sv @@
// Output channel carrying one surviving box per transfer.
// Field widths come from gbs_pkg.
interface gbs_kept_if;
	logic                        valid;
	logic                        ready;
	logic [gbs_pkg::COORD_W-1:0] kept_left;
	logic [gbs_pkg::COORD_W-1:0] kept_top;
	logic [gbs_pkg::COORD_W-1:0] kept_right;
	logic [gbs_pkg::COORD_W-1:0] kept_bottom;
	logic [gbs_pkg::COORD_W-1:0] kept_confidence;
	logic [gbs_pkg::COORD_W-1:0] kept_tag;
	logic                        store_overflow;

	modport source (output valid, kept_left, kept_top, kept_right, kept_bottom,
		kept_confidence, kept_tag, store_overflow, input ready);
	modport sink (input valid, kept_left, kept_top, kept_right, kept_bottom,
		kept_confidence, kept_tag, store_overflow, output ready);
endinterface

@@ rtl/gbs_cell.sv @@
// One kept-box cell: holds a stored box and tests a passing box against it.
// Uses gbs_pkg types and the extent helper; chained by the top level.
module gbs_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gbs_pkg::box_bus_t           box_i,
	input  logic                        hit_i,
	input  logic [gbs_pkg::THR_W-1:0]   thr,
	input  logic [CNT_W-1:0]            count,
	input  gbs_pkg::store_t             store,
	output gbs_pkg::box_bus_t           box_o,
	output logic                        hit_o,
	output logic                        hit_valid_o
);

	gbs_pkg::box_t                 kept_box_q;
	logic [gbs_pkg::AREA_W-1:0]    kept_area_q;
	logic                          pass_valid_q;
	gbs_pkg::box_t                 pass_box_q;
	logic [gbs_pkg::AREA_W-1:0]    pass_area_q;

	logic                          v_s1, v_s2, v_s3;
	logic                          act_s1, act_s2, act_s3;
	logic [gbs_pkg::EXT_W-1:0]     w_s1, h_s1;
	logic [gbs_pkg::SUM_W-1:0]     sum_s1, sum_s2, uni_s3;
	logic [gbs_pkg::AREA_W-1:0]    inter_s2, inter_s3;
	logic                          hit_q, hit_valid_q;

	logic [gbs_pkg::COORD_W-1:0]   ix1, iy1, ix2, iy2;
	logic                          active;
	logic [gbs_pkg::PROD_W-1:0]    lhs, rhs;
	logic                          own_hit;

	assign active = CNT_W'(IDX) < count;

	always_comb begin
		ix1 = (box_i.box.left > kept_box_q.left) ? box_i.box.left : kept_box_q.left;
		iy1 = (box_i.box.top > kept_box_q.top) ? box_i.box.top : kept_box_q.top;
		ix2 = (box_i.box.right < kept_box_q.right) ? box_i.box.right : kept_box_q.right;
		iy2 = (box_i.box.bottom < kept_box_q.bottom) ? box_i.box.bottom : kept_box_q.bottom;
	end

	// Division-free test: 256 * inter >= thr * union.
	assign lhs     = gbs_pkg::PROD_W'({inter_s3, gbs_pkg::IOU_SHIFT'(0)});
	assign rhs     = gbs_pkg::PROD_W'(thr) * gbs_pkg::PROD_W'(uni_s3);
	assign own_hit = act_s3 && (lhs >= rhs);

	always_ff @(posedge clk) begin
		if (store.en && count == CNT_W'(IDX)) begin
			kept_box_q  <= store.box;
			kept_area_q <= store.area;
		end
	end

	always_ff @(posedge clk) begin
		pass_box_q  <= box_i.box;
		pass_area_q <= box_i.area;
		w_s1        <= gbs_pkg::extent(ix1, ix2);
		h_s1        <= gbs_pkg::extent(iy1, iy2);
		sum_s1      <= gbs_pkg::SUM_W'(kept_area_q) + gbs_pkg::SUM_W'(box_i.area);
		act_s1      <= active;
		inter_s2    <= gbs_pkg::AREA_W'(w_s1) * gbs_pkg::AREA_W'(h_s1);
		sum_s2      <= sum_s1;
		act_s2      <= act_s1;
		uni_s3      <= sum_s2 - gbs_pkg::SUM_W'(inter_s2);
		inter_s3    <= inter_s2;
		act_s3      <= act_s2;
		hit_q       <= hit_i | own_hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_valid_q <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			hit_valid_q  <= 1'b0;
		end else begin
			pass_valid_q <= box_i.valid;
			v_s1         <= box_i.valid;
			v_s2         <= v_s1;
			v_s3         <= v_s2;
			hit_valid_q  <= v_s3;
		end
	end

	assign box_o       = {pass_valid_q, pass_box_q, pass_area_q};
	assign hit_o       = hit_q;
	assign hit_valid_o = hit_valid_q;

endmodule

@@ rtl/greedy_box_suppression.sv @@
// Top level of greedy box suppression: control, area unit, output register
// and the chain of gbs_cell instances. Depends on gbs_pkg and both interfaces.
//
//   port     | dir | handshake      | carries
//   boxes    | in  | valid / ready  | first_box, corners, confidence, tag
//   kept     | out | valid / ready  | surviving corners, confidence, tag, overflow
//   cfg_wr_* | in  | write enable   | overlap_threshold, 9 bits
//
// After a transfer the next one waits while the box passes the extent, area and
// launch states and walks the chain one cell a cycle, until the last cell's
// four-stage test closes the walk. A suppressed box leaves no result. A new box
// is taken while a result still waits in the output register; a second survivor
// then waits until that register empties. Reset empties the kept list and loads
// the threshold 102; the stored boxes themselves are not cleared.
module greedy_box_suppression #(
	parameter int MAX_KEPT = gbs_pkg::MAX_KEPT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	gbs_box_if.sink                   boxes,
	gbs_kept_if.source                kept,
	input  logic                      cfg_wr_en,
	input  logic [gbs_pkg::THR_W-1:0] cfg_wr_data
);

	localparam int CNT_W = $clog2(MAX_KEPT + 1);

	gbs_pkg::state_t               state_q, state_d;
	gbs_pkg::box_t                 cur_box_q;
	logic [gbs_pkg::COORD_W-1:0]   cur_conf_q, cur_tag_q;
	logic [gbs_pkg::EXT_W-1:0]     ext_w_q, ext_h_q;
	logic [gbs_pkg::AREA_W-1:0]    area_q;
	logic [CNT_W-1:0]              count_q;
	logic [gbs_pkg::THR_W-1:0]     thr_q;
	logic                          hit_q;
	logic                          out_valid_q;
	gbs_pkg::box_t                 out_box_q;
	logic [gbs_pkg::COORD_W-1:0]   out_conf_q, out_tag_q;
	logic                          out_ovf_q;

	logic                          take;
	logic                          launch;
	logic                          emit;
	logic                          out_free;
	logic                          full;
	gbs_pkg::store_t               store;
	gbs_pkg::box_bus_t             launch_bus;

	gbs_pkg::box_bus_t             chain_box [MAX_KEPT];
	logic [MAX_KEPT:0]             chain_hit;
	logic [MAX_KEPT-1:0]           chain_hv;

	assign take     = boxes.valid && boxes.ready;
	assign out_free = !out_valid_q || kept.ready;
	assign full     = count_q == CNT_W'(MAX_KEPT);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			gbs_pkg::ST_IDLE:   if (boxes.valid) state_d = gbs_pkg::ST_EXT;
			gbs_pkg::ST_EXT:    state_d = gbs_pkg::ST_AREA;
			gbs_pkg::ST_AREA:   state_d = gbs_pkg::ST_LAUNCH;
			gbs_pkg::ST_LAUNCH: state_d = gbs_pkg::ST_WALK;
			gbs_pkg::ST_WALK:   if (chain_hv[MAX_KEPT-1]) state_d = gbs_pkg::ST_FINISH;
			gbs_pkg::ST_FINISH: if (hit_q || out_free) state_d = gbs_pkg::ST_IDLE;
			default:            state_d = gbs_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		boxes.ready = 1'b0;
		launch      = 1'b0;
		emit        = 1'b0;
		case (state_q)
			gbs_pkg::ST_IDLE:   boxes.ready = 1'b1;
			gbs_pkg::ST_LAUNCH: launch = 1'b1;
			gbs_pkg::ST_FINISH: emit = !hit_q && out_free;
			default: begin
				boxes.ready = 1'b0;
			end
		endcase
	end

	assign store.en   = emit && !full;
	assign store.box  = cur_box_q;
	assign store.area = area_q;

	assign launch_bus.valid = launch;
	assign launch_bus.box   = cur_box_q;
	assign launch_bus.area  = area_q;

	assign chain_hit[0] = 1'b0;

	for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
		gbs_pkg::box_bus_t cell_in;
		if (i == 0) begin : g_head
			assign cell_in = launch_bus;
		end else begin : g_body
			assign cell_in = chain_box[i-1];
		end
		gbs_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.box_i       (cell_in),
			.hit_i       (chain_hit[i]),
			.thr         (thr_q),
			.count       (count_q),
			.store       (store),
			.box_o       (chain_box[i]),
			.hit_o       (chain_hit[i+1]),
			.hit_valid_o (chain_hv[i])
		);
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_box_q.left   <= boxes.left;
			cur_box_q.top    <= boxes.top;
			cur_box_q.right  <= boxes.right;
			cur_box_q.bottom <= boxes.bottom;
			cur_conf_q       <= boxes.confidence;
			cur_tag_q        <= boxes.tag;
		end
		if (state_q == gbs_pkg::ST_EXT) begin
			ext_w_q <= gbs_pkg::extent(cur_box_q.left, cur_box_q.right);
			ext_h_q <= gbs_pkg::extent(cur_box_q.top, cur_box_q.bottom);
		end
		if (state_q == gbs_pkg::ST_AREA) begin
			area_q <= gbs_pkg::AREA_W'(ext_w_q) * gbs_pkg::AREA_W'(ext_h_q);
		end
		if (chain_hv[MAX_KEPT-1]) begin
			hit_q <= chain_hit[MAX_KEPT];
		end
		if (emit) begin
			out_box_q  <= cur_box_q;
			out_conf_q <= cur_conf_q;
			out_tag_q  <= cur_tag_q;
			out_ovf_q  <= full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gbs_pkg::ST_IDLE;
			count_q     <= '0;
			thr_q       <= gbs_pkg::THR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end
			// A new frame empties the list before its first box is tested.
			if (take && boxes.first_box) begin
				count_q <= '0;
			end else if (store.en) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (kept.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign kept.valid           = out_valid_q;
	assign kept.kept_left       = out_box_q.left;
	assign kept.kept_top        = out_box_q.top;
	assign kept.kept_right      = out_box_q.right;
	assign kept.kept_bottom     = out_box_q.bottom;
	assign kept.kept_confidence = out_conf_q;
	assign kept.kept_tag        = out_tag_q;
	assign kept.store_overflow  = out_ovf_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_KEPT))
		else $error("kept count beyond the store depth");

	a_store_room: assert property (@(posedge clk) disable iff (!arst_n)
		store.en |-> (count_q < CNT_W'(MAX_KEPT)) && !hit_q)
		else $error("store write without room or for a suppressed box");

	a_store_count: assert property (@(posedge clk) disable iff (!arst_n)
		store.en |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("kept count did not advance after a store");

	a_walk_only: assert property (@(posedge clk) disable iff (!arst_n)
		(chain_hv[MAX_KEPT-1] || chain_box[MAX_KEPT-1].valid) |->
		state_q == gbs_pkg::ST_WALK)
		else $error("chain activity outside the walk");

	a_emit_once: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> !emit)
		else $error("one box emitted twice");

endmodule
